// ===== design/drti_pkg.sv =====
// ----------------------------------------------------------------------------
// drti_pkg
// Types and constants shared by the round-to-integral unit.
// ----------------------------------------------------------------------------
package drti_pkg;

    localparam int unsigned ExpBits  = 11;
    localparam int unsigned MantBits = 52;
    localparam logic [ExpBits-1:0] ExpOffset = 11'd1023;
    localparam logic [ExpBits-1:0] ExpBig    = 11'd1075;
    localparam logic [ExpBits-1:0] ExpMax    = 11'h7ff;
    localparam logic [63:0] SignBit  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MinusOne = 64'hbff0_0000_0000_0000;

    typedef enum logic [1:0] {
        OP_FLOOR = 2'd0,
        OP_CEIL  = 2'd1,
        OP_SPLIT = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] value_bits;
    } t_in_item;

    typedef struct packed {
        logic [63:0] integral_bits;
        logic [63:0] fraction_bits;
    } t_out_item;

endpackage

// ===== design/double_round_to_integral_unit.sv =====
// ----------------------------------------------------------------------------
// double_round_to_integral_unit
// Floor, ceil and integral/fraction split of IEEE-754 double bit patterns.
// ----------------------------------------------------------------------------
// The unit takes one item per cycle while input ready is high; an item
// registered at the input passes through the bit-level rounding logic into a
// result register, which drives output valid and the output item.
// A new item is taken every cycle while the input register is empty or can
// move on, that is while the result register is empty or being drained in the
// same cycle; with both registers full and the result held, input ready drops.
module double_round_to_integral_unit
    import drti_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;
    logic      move;

    // The result register moves when it is empty or being taken.
    assign move    = !r_out_valid || i_ready;
    assign o_ready = !r_in_valid || move;
    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    drti_core u_core (
        .i_item (r_in_item),
        .o_item (n_out_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (move) begin
                r_out_valid <= r_in_valid;
            end
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
        end
        if (move && r_in_valid) begin
            r_out_item <= n_out_item;
        end
        if (o_ready && i_valid) begin
            r_in_item <= i_item;
        end
    end

endmodule

// ===== design/drti_core.sv =====
// ----------------------------------------------------------------------------
// drti_core
// Combinational floor, ceil and split of one double bit pattern.
// ----------------------------------------------------------------------------
module drti_core
    import drti_pkg::*;
(
    input  t_in_item  i_item,
    output t_out_item o_item
);

    logic [63:0] u;
    logic [63:0] uf;
    logic [ExpBits-1:0] be;
    logic [5:0]  sh;
    logic [63:0] mask;
    logic [63:0] fl;
    logic [63:0] tr;
    logic [63:0] f;
    logic [63:0] frac;
    logic [5:0]  p;
    logic [63:0] fnorm;
    logic [ExpBits-1:0] fexp;

    // Floor of a sign-adjusted operand; ceil flips the sign around it.
    always_comb begin
        u    = i_item.value_bits;
        uf   = (i_item.operation == OP_CEIL) ? (u ^ SignBit) : u;
        be   = u[62:52];
        sh   = 6'(ExpBig - be);
        mask = (64'd1 << sh) - 64'd1;
        tr   = u & ~mask;
        if (be >= ExpBig) begin
            fl = uf;
        end else if (be < ExpOffset) begin
            if (uf[63]) begin
                fl = (uf[62:0] == 63'd0) ? uf : MinusOne;
            end else begin
                fl = 64'd0;
            end
        end else if ((uf & mask) == 64'd0) begin
            fl = uf;
        end else begin
            fl = (uf & ~mask) + (uf[63] ? (64'd1 << sh) : 64'd0);
        end
        // Fraction: find leading one of the dropped bits and renormalize.
        f = u & mask;
        p = 6'd0;
        for (int i = 0; i < 52; i++) begin
            if (f[i]) begin
                p = 6'(i);
            end
        end
        fnorm = f << (6'd52 - p);
        fexp  = ExpOffset - ExpBits'(sh) + ExpBits'(p);
        if (be >= ExpBig) begin
            frac = (be == ExpMax && u[51:0] != 52'd0) ? u : (u & SignBit);
        end else if (be < ExpOffset) begin
            frac = u;
        end else if (f == 64'd0) begin
            frac = u & SignBit;
        end else begin
            frac = {u[63], fexp, fnorm[51:0]};
        end
        unique case (t_op'(i_item.operation))
            OP_FLOOR: o_item = '{integral_bits: fl, fraction_bits: 64'd0};
            OP_CEIL:  o_item = '{integral_bits: fl ^ SignBit, fraction_bits: 64'd0};
            OP_SPLIT: o_item = '{
                integral_bits: (be >= ExpBig) ? u : ((be < ExpOffset) ? (u & SignBit) : tr),
                fraction_bits: frac};
            default:  o_item = '{integral_bits: 64'd0, fraction_bits: 64'd0};
        endcase
    end

endmodule
